/* sv/stsp_pkg.sv */
// ----------------------------------------------------------------------------
// stsp_pkg
// Types, codes and small tables for the transaction stream parser.
// ----------------------------------------------------------------------------
package stsp_pkg;

    localparam int unsigned LenW     = 24;
    localparam logic [LenW-1:0] MaxLengthReset = 24'd200000;

    localparam logic [7:0] VarintMax16 = 8'hfd;
    localparam logic [7:0] VarintMax32 = 8'hfe;
    localparam logic [31:0] InputLimit = 32'h0000_ffff;
    localparam logic [31:0] OutScriptLen = 32'h0000_0019;

    localparam logic [5:0] PrevLen  = 6'd36;
    localparam logic [5:0] WordLen  = 6'd4;
    localparam logic [5:0] AmtLen   = 6'd8;
    localparam logic [5:0] PreLen   = 6'd3;
    localparam logic [5:0] HashLen  = 6'd20;
    localparam logic [5:0] PostLen  = 6'd2;

    typedef enum logic [3:0] {
        PH_VER, PH_NIN, PH_PREV, PH_SLEN, PH_SCRIPT, PH_SEQ, PH_NOUT, PH_AMT,
        PH_OSLEN, PH_OPRE, PH_HASH, PH_OPOST, PH_LOCK, PH_HTYPE, PH_END
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK, ST_FORMAT, ST_TOO_LARGE, ST_TOO_MANY_IN, ST_TOO_MANY_OUT, ST_NONSTD
    } t_status;

    typedef enum logic [1:0] {
        VI_PEND, VI_DONE, VI_BAD
    } t_vstat;

    localparam logic [1:0] KIND_OTHER  = 2'd0;
    localparam logic [1:0] KIND_AMOUNT = 2'd1;
    localparam logic [1:0] KIND_HASH   = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        into_sig_hash;
        logic        into_tx_hash;
        logic [1:0]  field_kind;
        logic [4:0]  field_pos;
        logic [7:0]  output_number;
        logic        done_res;
        logic [2:0]  status;
        logic [15:0] input_count;
    } t_out_item;

    // length of the fixed-size field read in a phase
    function automatic logic [5:0] fixed_len(input t_phase ph);
        logic [5:0] len;
        begin
            unique case (ph)
                PH_VER, PH_SEQ, PH_LOCK, PH_HTYPE: len = WordLen;
                PH_PREV:  len = PrevLen;
                PH_AMT:   len = AmtLen;
                PH_OPRE:  len = PreLen;
                PH_HASH:  len = HashLen;
                PH_OPOST: len = PostLen;
                default:  len = 6'd0;
            endcase
            return len;
        end
    endfunction

    function automatic logic pat_used(input t_phase ph);
        return (ph == PH_VER) || (ph == PH_OPRE) || (ph == PH_OPOST) ||
               (ph == PH_LOCK) || (ph == PH_HTYPE);
    endfunction

    // expected byte, picked by bytes still to come in the field
    function automatic logic [7:0] pat_byte(input t_phase ph, input logic [5:0] left);
        logic [7:0] pb;
        begin
            unique case (ph)
                PH_VER, PH_HTYPE: pb = (left == 6'd4) ? 8'h01 : 8'h00;
                PH_OPRE:  pb = (left == 6'd3) ? 8'h76 : ((left == 6'd2) ? 8'ha9 : 8'h14);
                PH_OPOST: pb = (left == 6'd2) ? 8'h88 : 8'hac;
                default:  pb = 8'h00;
            endcase
            return pb;
        end
    endfunction

endpackage

/* sv/stsp_if.sv */
// ----------------------------------------------------------------------------
// stsp_in_if / stsp_out_if
// Valid/ready channels for input bytes and tagged result bytes.
// ----------------------------------------------------------------------------
interface stsp_in_if import stsp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stsp_out_if import stsp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/stsp_core.sv */
// ----------------------------------------------------------------------------
// stsp_core
// Parse state and per-byte decode: tags one byte and advances the state.
// ----------------------------------------------------------------------------
module stsp_core import stsp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  t_in_item        i_item,
    input  logic [LenW-1:0] i_max_length,
    output t_out_item       o_res
);

    t_phase      r_phase, n_phase;
    logic [23:0] r_bcnt, n_bcnt;
    logic [5:0]  r_fbl, n_fbl;
    logic [31:0] r_vval, n_vval;
    logic [2:0]  r_vleft, n_vleft;
    logic [31:0] r_sbl, n_sbl;
    logic [15:0] r_itot, n_itot;
    logic [15:0] r_idone, n_idone;
    logic [7:0]  r_otot, n_otot;
    logic [7:0]  r_odone, n_odone;
    t_status     r_err, n_err;
    logic        r_mis, n_mis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_VER;
            r_bcnt  <= '0;
            r_fbl   <= WordLen;
            r_vval  <= '0;
            r_vleft <= '0;
            r_sbl   <= '0;
            r_itot  <= '0;
            r_idone <= '0;
            r_otot  <= '0;
            r_odone <= '0;
            r_err   <= ST_OK;
            r_mis   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bcnt  <= n_bcnt;
            r_fbl   <= n_fbl;
            r_vval  <= n_vval;
            r_vleft <= n_vleft;
            r_sbl   <= n_sbl;
            r_itot  <= n_itot;
            r_idone <= n_idone;
            r_otot  <= n_otot;
            r_odone <= n_odone;
            r_err   <= n_err;
            r_mis   <= n_mis;
        end
    end

    always_comb begin
        logic [7:0]  b;
        t_vstat      vi_stat;
        logic [31:0] vi_val;
        logic [5:0]  vi_fbl;
        logic [2:0]  vi_left;
        logic [5:0]  fx_len;
        logic        fx_skip;
        logic        fx_done;
        logic [5:0]  fx_fbl;
        logic        fx_mis;
        logic        ent;
        t_phase      ent_ph;
        logic [5:0]  ent_len;
        logic [31:0] sbl_dec;
        logic [15:0] idone_inc;
        logic [7:0]  odone_inc;
        t_status     fin;

        b = i_item.data_byte;

        n_phase = r_phase;
        n_bcnt  = r_bcnt;
        n_fbl   = r_fbl;
        n_vval  = r_vval;
        n_vleft = r_vleft;
        n_sbl   = r_sbl;
        n_itot  = r_itot;
        n_idone = r_idone;
        n_otot  = r_otot;
        n_odone = r_odone;
        n_err   = r_err;
        n_mis   = r_mis;
        ent     = 1'b0;
        ent_ph  = r_phase;
        ent_len = '0;
        fin     = ST_OK;

        o_res = '0;
        o_res.byte_out = b;
        o_res.done_res = i_item.last_byte;

        // varint decode step
        vi_stat = VI_PEND;
        vi_val  = r_vval;
        vi_fbl  = r_fbl;
        vi_left = r_vleft;
        if (r_vleft == 3'd0) begin
            if (b < VarintMax16) begin
                vi_stat = VI_DONE;
                vi_val  = {24'd0, b};
            end else if (b == VarintMax16) begin
                vi_left = 3'd2;
                vi_val  = '0;
                vi_fbl  = '0;
            end else if (b == VarintMax32) begin
                vi_left = 3'd4;
                vi_val  = '0;
                vi_fbl  = '0;
            end else begin
                vi_stat = VI_BAD;
            end
        end else begin
            vi_val  = r_vval | ({24'd0, b} << {r_fbl[1:0], 3'b000});
            vi_fbl  = r_fbl + 6'd1;
            vi_left = r_vleft - 3'd1;
            vi_stat = (r_vleft == 3'd1) ? VI_DONE : VI_PEND;
        end

        // fixed-size field step
        fx_len  = fixed_len(r_phase);
        fx_skip = (r_fbl == 6'd0) || (r_fbl > fx_len);
        fx_done = fx_skip || (r_fbl == 6'd1);
        fx_fbl  = fx_skip ? r_fbl : (r_fbl - 6'd1);
        fx_mis  = r_mis | (!fx_skip && pat_used(r_phase) && (pat_byte(r_phase, r_fbl) != b));

        sbl_dec   = (r_sbl != 32'd0) ? (r_sbl - 32'd1) : r_sbl;
        idone_inc = r_idone + 16'd1;
        odone_inc = r_odone + 8'd1;

        if (r_err == ST_OK && r_bcnt >= i_max_length) begin
            n_err = ST_TOO_LARGE;
        end
        if (r_bcnt != 24'hff_ffff) begin
            n_bcnt = r_bcnt + 24'd1;
        end

        if (n_err == ST_OK) begin
            o_res.into_sig_hash = 1'b1;
            o_res.into_tx_hash  = !((r_phase == PH_SLEN) || (r_phase == PH_SCRIPT));
            if (r_phase == PH_AMT && r_fbl >= 6'd1 && r_fbl <= AmtLen) begin
                o_res.field_kind    = KIND_AMOUNT;
                o_res.field_pos     = 5'(AmtLen - r_fbl);
                o_res.output_number = r_odone;
            end else if (r_phase == PH_HASH && r_fbl >= 6'd1 && r_fbl <= HashLen) begin
                o_res.field_kind    = KIND_HASH;
                o_res.field_pos     = 5'(HashLen - r_fbl);
                o_res.output_number = r_odone;
            end

            unique case (r_phase)
                PH_VER: begin
                    n_fbl = fx_fbl;
                    n_mis = fx_mis;
                    if (fx_done) begin
                        if (fx_mis) n_err = ST_FORMAT;
                        else begin
                            ent = 1'b1; ent_ph = PH_NIN; ent_len = '0;
                        end
                    end
                end
                PH_NIN: begin
                    n_fbl = vi_fbl; n_vleft = vi_left; n_vval = vi_val;
                    if (vi_stat == VI_BAD) n_err = ST_FORMAT;
                    else if (vi_stat == VI_DONE) begin
                        if (vi_val == 32'd0) n_err = ST_FORMAT;
                        else if (vi_val >= InputLimit) n_err = ST_TOO_MANY_IN;
                        else begin
                            n_itot  = vi_val[15:0];
                            n_idone = '0;
                            ent = 1'b1; ent_ph = PH_PREV; ent_len = PrevLen;
                        end
                    end
                end
                PH_PREV, PH_AMT, PH_HASH: begin
                    n_fbl = fx_fbl;
                    n_mis = fx_mis;
                    if (fx_done) begin
                        ent = 1'b1;
                        unique case (r_phase)
                            PH_PREV: begin ent_ph = PH_SLEN;  ent_len = '0;     end
                            PH_AMT:  begin ent_ph = PH_OSLEN; ent_len = '0;     end
                            default: begin ent_ph = PH_OPOST; ent_len = PostLen; end
                        endcase
                    end
                end
                PH_SLEN: begin
                    n_fbl = vi_fbl; n_vleft = vi_left; n_vval = vi_val;
                    if (vi_stat == VI_BAD) n_err = ST_FORMAT;
                    else if (vi_stat == VI_DONE) begin
                        n_sbl = vi_val;
                        ent   = 1'b1;
                        if (vi_val == 32'd0) begin
                            ent_ph = PH_SEQ; ent_len = WordLen;
                        end else begin
                            ent_ph = PH_SCRIPT; ent_len = '0;
                        end
                    end
                end
                PH_SCRIPT: begin
                    n_sbl = sbl_dec;
                    if (sbl_dec == 32'd0) begin
                        ent = 1'b1; ent_ph = PH_SEQ; ent_len = WordLen;
                    end
                end
                PH_SEQ: begin
                    n_fbl = fx_fbl;
                    n_mis = fx_mis;
                    if (fx_done) begin
                        n_idone = idone_inc;
                        ent     = 1'b1;
                        if (idone_inc >= r_itot) begin
                            ent_ph = PH_NOUT; ent_len = 6'd1;
                        end else begin
                            ent_ph = PH_PREV; ent_len = PrevLen;
                        end
                    end
                end
                PH_NOUT: begin
                    if (b == 8'd0) n_err = ST_FORMAT;
                    else if (b >= VarintMax16) n_err = ST_TOO_MANY_OUT;
                    else begin
                        n_otot  = b;
                        n_odone = '0;
                        ent = 1'b1; ent_ph = PH_AMT; ent_len = AmtLen;
                    end
                end
                PH_OSLEN: begin
                    n_fbl = vi_fbl; n_vleft = vi_left; n_vval = vi_val;
                    if (vi_stat == VI_BAD) n_err = ST_FORMAT;
                    else if (vi_stat == VI_DONE) begin
                        if (vi_val != OutScriptLen) n_err = ST_NONSTD;
                        else begin
                            ent = 1'b1; ent_ph = PH_OPRE; ent_len = PreLen;
                        end
                    end
                end
                PH_OPRE, PH_LOCK, PH_HTYPE: begin
                    n_fbl = fx_fbl;
                    n_mis = fx_mis;
                    if (fx_done) begin
                        if (fx_mis) n_err = ST_NONSTD;
                        else begin
                            ent = 1'b1;
                            unique case (r_phase)
                                PH_OPRE: begin ent_ph = PH_HASH;  ent_len = HashLen; end
                                PH_LOCK: begin ent_ph = PH_HTYPE; ent_len = WordLen; end
                                default: begin ent_ph = PH_END;   ent_len = '0;      end
                            endcase
                        end
                    end
                end
                PH_OPOST: begin
                    n_fbl = fx_fbl;
                    n_mis = fx_mis;
                    if (fx_done) begin
                        if (fx_mis) n_err = ST_NONSTD;
                        else begin
                            n_odone = odone_inc;
                            ent     = 1'b1;
                            if (odone_inc >= r_otot) begin
                                ent_ph = PH_LOCK; ent_len = WordLen;
                            end else begin
                                ent_ph = PH_AMT; ent_len = AmtLen;
                            end
                        end
                    end
                end
                default: begin
                    // junk after a complete transaction
                    n_err = ST_FORMAT;
                end
            endcase

            if (ent) begin
                n_phase = ent_ph;
                n_fbl   = ent_len;
                n_vleft = '0;
                n_vval  = '0;
                n_mis   = 1'b0;
            end
        end

        if (i_item.last_byte) begin
            fin = n_err;
            if (n_err == ST_OK && n_phase != PH_END) fin = ST_FORMAT;
            o_res.status      = fin;
            o_res.input_count = n_itot;
            // next byte opens a fresh transaction
            n_phase = PH_VER;
            n_bcnt  = '0;
            n_fbl   = WordLen;
            n_vval  = '0;
            n_vleft = '0;
            n_sbl   = '0;
            n_itot  = '0;
            n_idone = '0;
            n_otot  = '0;
            n_odone = '0;
            n_err   = ST_OK;
            n_mis   = 1'b0;
        end
    end

endmodule

/* sv/standard_transaction_stream_parser.sv */
// ----------------------------------------------------------------------------
// standard_transaction_stream_parser
// Byte-serial checker and tagger for standard pay-to-address transactions.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-------------------------------------------
//  i_in      | in  | valid/ready   | data_byte, last_byte
//  o_out     | out | valid/ready   | byte_out, hash flags, tags, status, count
//  i_cfg_*   | in  | write enable  | max_length (24 bit)
//
//  one byte per cycle sustained while the output is not stalled; a byte passes
//  the input register, then the core and the output register. The rate is set by
//  the per-byte state update in the core, one step a cycle while not stalled;
//  synchronous reset clears the parse state and sets max_length to 200000;
//  a stalled output holds its result; the input register still takes a byte
//  while it is empty or while the output is free or being drained
module standard_transaction_stream_parser import stsp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [LenW-1:0] i_cfg_wdata,
    stsp_in_if.sink         i_in,
    stsp_out_if.source      o_out
);

    logic            r_in_vld;
    t_in_item        r_in_item;
    logic            r_out_vld;
    t_out_item       r_out_item;
    logic [LenW-1:0] r_max_length;
    logic            w_adv;
    logic            w_accept;
    t_out_item       w_res;

    assign w_adv      = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_adv;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MaxLengthReset;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= i_in.data;
        end
    end

    stsp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_adv),
        .i_item       (r_in_item),
        .i_max_length (r_max_length),
        .o_res        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_item <= w_res;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out_item;

endmodule

/* sv/stsp_checker.sv */
// ----------------------------------------------------------------------------
// stsp_port_checker
// Port-level checks on the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module stsp_port_checker import stsp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // stalled transfer keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("output payload changed while stalled");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // tx hash and tags only on parsed bytes
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((!i_out_data.into_tx_hash || i_out_data.into_sig_hash) &&
                         (i_out_data.field_kind == KIND_OTHER ||
                          i_out_data.into_sig_hash) &&
                         (i_out_data.field_kind != KIND_OTHER ||
                          (i_out_data.field_pos == 5'd0 &&
                           i_out_data.output_number == 8'd0))))
        else $error("inconsistent hash flags or tags");

    // status and count only on the final byte
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_data.done_res) |->
            (i_out_data.status == ST_OK && i_out_data.input_count == 16'd0))
        else $error("status reported before final byte");

    // a result only follows an input transfer
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2) ||
                               $past(i_in_valid && i_in_ready, 1) ||
                               $past(i_out_valid, 1))
        else $error("result without input transfer");

endmodule

bind standard_transaction_stream_parser stsp_port_checker u_stsp_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
